>>> rtl/mtc_pkg.sv
package mtc_pkg;

    // Field widths
    localparam int BYTE_W = 7;
    localparam int NIB_W  = 4;
    localparam int CNT_W  = 8;
    localparam int HOUR_W = 5;
    localparam int RATE_W = 7;

    // Limits and rates
    localparam logic [RATE_W-1:0] LIMIT_MINSEC = 7'd60;
    localparam logic [RATE_W-1:0] RATE_24      = 7'd24;
    localparam logic [RATE_W-1:0] RATE_25      = 7'd25;
    localparam logic [RATE_W-1:0] RATE_30      = 7'd30;
    localparam logic [RATE_W-1:0] RATE_UNKNOWN = 7'd100;

    // An 8-bit count plus one (at most 256) over the smallest limit (24) holds at most ten limits
    localparam int MAX_QUOT = 10;

    // Piece numbers that advance the time, and the one that sets the rate
    localparam logic [2:0] PIECE_FRAME_LO = 3'd0;
    localparam logic [2:0] PIECE_MIN_LO   = 3'd4;
    localparam logic [2:0] PIECE_HOUR_HI  = 3'd7;

    // Field select from the upper two piece bits
    localparam logic [1:0] SEL_FRAME  = 2'd0;
    localparam logic [1:0] SEL_SECOND = 2'd1;
    localparam logic [1:0] SEL_MINUTE = 2'd2;
    localparam logic [1:0] SEL_HOUR   = 2'd3;

    // Rate codes (nibble bits 3..1)
    localparam logic [2:0] CODE_24    = 3'd0;
    localparam logic [2:0] CODE_25    = 3'd1;
    localparam logic [2:0] CODE_30DF  = 3'd2;
    localparam logic [2:0] CODE_30    = 3'd3;

    typedef struct packed {
        logic [CNT_W-1:0]  frames;
        logic [CNT_W-1:0]  seconds;
        logic [CNT_W-1:0]  minutes;
        logic [HOUR_W-1:0] hours;
    } mtc_time_t;

    typedef struct packed {
        logic              new_frame;
        mtc_time_t         time_val;
        logic [RATE_W-1:0] rate;
    } mtc_result_t;

    function automatic logic [RATE_W-1:0] rate_from_code(input logic [2:0] code);
        logic [RATE_W-1:0] r;
        case (code)
            CODE_24:   r = RATE_24;
            CODE_25:   r = RATE_25;
            CODE_30DF: r = RATE_30;
            CODE_30:   r = RATE_30;
            default:   r = RATE_UNKNOWN;
        endcase
        return r;
    endfunction

    // Remainder of a 9-bit count by a 7-bit limit: parallel compares
    // against the multiples of the limit, then one subtract.
    function automatic logic [CNT_W-1:0] mod_limit(input logic [CNT_W:0] v,
                                                   input logic [RATE_W-1:0] d);
        logic [9:0] sub;
        logic [9:0] mult;
        sub = '0;
        for (int i = 1; i <= MAX_QUOT; i++) begin
            mult = 10'(i) * {3'b000, d};
            if ({1'b0, v} >= mult) begin
                sub = mult;
            end
        end
        return CNT_W'({1'b0, v} - sub);
    endfunction

endpackage

>>> rtl/mtc_update.sv
module mtc_update (
    input  logic [mtc_pkg::BYTE_W-1:0] data_byte,
    input  mtc_pkg::mtc_time_t         time_cur,
    input  logic [mtc_pkg::RATE_W-1:0] rate_cur,
    output mtc_pkg::mtc_time_t         time_next,
    output logic [mtc_pkg::RATE_W-1:0] rate_next,
    output mtc_pkg::mtc_result_t       result
);
    import mtc_pkg::*;

    logic [2:0]       piece;
    logic [NIB_W-1:0] nib;
    logic             adv;
    logic [CNT_W:0]   f_inc;
    logic [CNT_W:0]   s_inc;
    logic [CNT_W:0]   m_inc;
    logic             f_carry;
    logic             s_carry;
    logic             m_carry;
    mtc_time_t        time_adv;
    logic [CNT_W-1:0] nib_hi;

    assign piece  = data_byte[6:4];
    assign nib    = data_byte[3:0];
    assign adv    = (piece == PIECE_FRAME_LO) || (piece == PIECE_MIN_LO);
    assign nib_hi = {nib, 4'b0000};

    // Frame advance with carries into seconds, minutes and hours
    assign f_inc   = {1'b0, time_cur.frames} + 9'd1;
    assign s_inc   = {1'b0, time_cur.seconds} + 9'd1;
    assign m_inc   = {1'b0, time_cur.minutes} + 9'd1;
    assign f_carry = f_inc >= {2'b00, rate_cur};
    assign s_carry = f_carry && (s_inc >= {2'b00, LIMIT_MINSEC});
    assign m_carry = s_carry && (m_inc >= {2'b00, LIMIT_MINSEC});

    always_comb
    begin
        time_adv = time_cur;
        if (adv)
        begin
            time_adv.frames = f_carry ? mod_limit(f_inc, rate_cur) : f_inc[CNT_W-1:0];
            if (f_carry)
            begin
                time_adv.seconds = s_carry ? mod_limit(s_inc, LIMIT_MINSEC)
                                           : s_inc[CNT_W-1:0];
            end
            if (s_carry)
            begin
                time_adv.minutes = m_carry ? mod_limit(m_inc, LIMIT_MINSEC)
                                           : m_inc[CNT_W-1:0];
            end
            if (m_carry)
            begin
                time_adv.hours = time_cur.hours + 5'd1;
            end
        end
    end

    // Nibble write: even piece sets the field, odd piece ORs in the high nibble
    always_comb
    begin
        time_next = time_adv;
        case (piece[2:1])
            SEL_FRAME:
            begin
                time_next.frames = piece[0] ? (time_adv.frames | nib_hi)
                                            : {4'b0000, nib};
            end
            SEL_SECOND:
            begin
                time_next.seconds = piece[0] ? (time_adv.seconds | nib_hi)
                                             : {4'b0000, nib};
            end
            SEL_MINUTE:
            begin
                time_next.minutes = piece[0] ? (time_adv.minutes | nib_hi)
                                             : {4'b0000, nib};
            end
            SEL_HOUR:
            begin
                time_next.hours = piece[0] ? (time_adv.hours | {nib[0], 4'b0000})
                                           : {1'b0, nib};
            end
            default:
            begin
                time_next = time_adv;
            end
        endcase
    end

    // Rate selection on the last piece
    assign rate_next = (piece == PIECE_HOUR_HI) ? rate_from_code(nib[3:1]) : rate_cur;

    // Result shows the time after the advance and the rate used for it
    assign result.new_frame = adv;
    assign result.time_val  = time_adv;
    assign result.rate      = rate_cur;

endmodule

>>> rtl/midi_timecode_quarter_frame_decoder.sv
// Pipeline: input register, then result register; an item moves on once the result register is free.
// Throughput: one item per cycle while out_ready stays high; the time update is one combinational pass
// between the input register and the result register.
// Reset: asynchronous, active low; time clears to zero, rate returns to 100,
// both pipeline stages empty.
module midi_timecode_quarter_frame_decoder (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [mtc_pkg::BYTE_W-1:0]  data_byte,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        new_frame,
    output logic [mtc_pkg::CNT_W-1:0]   frame_count,
    output logic [mtc_pkg::CNT_W-1:0]   second_count,
    output logic [mtc_pkg::CNT_W-1:0]   minute_count,
    output logic [mtc_pkg::HOUR_W-1:0]  hour_count,
    output logic [mtc_pkg::RATE_W-1:0]  frame_rate
);
    import mtc_pkg::*;

    logic              in_valid_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic              out_valid_reg;
    mtc_result_t       result_reg;
    mtc_time_t         time_reg;
    logic [RATE_W-1:0] rate_reg;

    mtc_time_t         time_next;
    logic [RATE_W-1:0] rate_next;
    mtc_result_t       result_next;
    logic              stage_move;

    // Item leaves the input register when the result register is free
    assign stage_move = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !in_valid_reg || stage_move;

    mtc_update u_update (
        .data_byte (byte_reg),
        .time_cur  (time_reg),
        .rate_cur  (rate_reg),
        .time_next (time_next),
        .rate_next (rate_next),
        .result    (result_next)
    );

    // Control and kept state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            time_reg      <= '0;
            rate_reg      <= RATE_UNKNOWN;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (stage_move)
            begin
                out_valid_reg <= 1'b1;
                time_reg      <= time_next;
                rate_reg      <= rate_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= data_byte;
        end
        if (stage_move)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign new_frame    = result_reg.new_frame;
    assign frame_count  = result_reg.time_val.frames;
    assign second_count = result_reg.time_val.seconds;
    assign minute_count = result_reg.time_val.minutes;
    assign hour_count   = result_reg.time_val.hours;
    assign frame_rate   = result_reg.rate;

    // An empty result stage never holds off the input side
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with empty result stage");

    // A waiting item with a free result stage shows up next cycle
    a_item_moves: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !out_valid_reg |=> out_valid_reg)
        else $error("item not moved into result stage");

    // The kept rate is always one of the supported values
    a_rate_legal: assert property (@(posedge clk) disable iff (!rst_n)
        rate_reg == RATE_24 || rate_reg == RATE_25 ||
        rate_reg == RATE_30 || rate_reg == RATE_UNKNOWN)
        else $error("kept frame rate out of set");

    // After an advance the frame count lies below the rate
    a_frame_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.new_frame |-> {1'b0, frame_count} < {2'b00, frame_rate})
        else $error("advanced frame count not reduced");

endmodule
